>>> rtl/bfa_pkg.sv
// bitmap frame allocator: shared types, action codes and sequencer states
// used by bfa_ffz and bitmap_frame_allocator_unit; no dependencies
`timescale 1ns / 1ps

package bfa_pkg;

  localparam int WORD_W = 64;
  localparam int POS_W  = 6;
  localparam int CNT_W  = 17;
  localparam logic [CNT_W-1:0] COUNT_MAX = 17'h1FFFF;

  typedef enum logic [1:0] {
    ACT_RELEASE = 2'd0,
    ACT_RESERVE = 2'd1,
    ACT_ALLOC   = 2'd2,
    ACT_FREE    = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TOP_SCAN,
    ST_SUM_FRD,
    ST_SUM_FIND,
    ST_MAP_RD,
    ST_MAP_MOD,
    ST_SUM_RD,
    ST_SUM_MOD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } ffz_res_t;

endpackage

>>> rtl/bfa_ffz.sv
// bitmap frame allocator: lowest-clear-bit finder over one 64-bit word,
// shared by every level of the search; depends on bfa_pkg
`timescale 1ns / 1ps

module bfa_ffz (
  input  logic [bfa_pkg::WORD_W-1:0] word,
  output bfa_pkg::ffz_res_t          res
);

  always_comb begin
    res.found = 1'b0;
    res.pos   = '0;
    // scan from the top so the lowest clear bit wins
    for (int i = bfa_pkg::WORD_W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        res.found = 1'b1;
        res.pos   = bfa_pkg::POS_W'(i);
      end
    end
  end

endmodule

>>> rtl/bitmap_frame_allocator_unit.sv
// bitmap frame allocator, first fit: three-level used map (map words,
// summary words, top flops) searched by one shared 64-bit finder
// depends on bfa_pkg and bfa_ffz
//
// usage:
//   in_* carries one request per transfer: action and frame_index.
//   out_* returns exactly one result per request: granted frame,
//   succeeded flag and the free frame count after the action.
//   one request is worked at a time; in_tready is high only when idle.
//   states from input transfer to result ready:
//     release, reserve, free of a set bit: map read, map modify,
//     summary read, summary modify, done; free of a clear bit: map
//     read, map modify, done; index beyond FRAMES: straight to done;
//     allocate: top scan chunk by chunk, top chunks = ceil(FRAMES/262144),
//     summary read, summary find, then the release steps; a failed
//     allocate goes to done after the scan. the next request is taken the cycle after a result is loaded.
//   the map memory's single read and write port sets the step count:
//   every map or summary word change is a read then a write.
//   after reset a clearing pass writes every map and summary word to
//   all used; in_tready stays low meanwhile.
//   the result sits in an output register; a stalled receiver holds the
//   block only once the next result is ready behind it.
`timescale 1ns / 1ps

module bitmap_frame_allocator_unit #(
  parameter int FRAMES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [1:0] action, [17:2] frame_index, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [15:0] granted_frame, [16] succeeded,
                                  // [33:17] free_frames, rest zero
);

  localparam int W          = bfa_pkg::WORD_W;
  localparam int MAP_WORDS  = (FRAMES + W - 1) / W;
  localparam int SUM_WORDS  = (MAP_WORDS + W - 1) / W;
  localparam int TOP_CHUNKS = (SUM_WORDS + W - 1) / W;
  localparam int TOP_BITS   = TOP_CHUNKS * W;
  localparam int TB_W       = $clog2(TOP_BITS);
  localparam int MW_W       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int SW_W       = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
  localparam int CH_W       = (TOP_CHUNKS > 1) ? $clog2(TOP_CHUNKS) : 1;
  localparam logic [31:0] FRAMES_U   = 32'(FRAMES);
  localparam logic [MW_W-1:0] MW_LAST = MW_W'(MAP_WORDS - 1);
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(TOP_CHUNKS - 1);
  localparam logic [31:0] SUM_WORDS_U = 32'(SUM_WORDS);

  localparam int CW = bfa_pkg::CNT_W;

  bfa_pkg::state_t state_r, state_nxt;

  // request and work registers
  bfa_pkg::action_t               act_r;
  logic [MW_W-1:0]                waddr_r;
  logic [SW_W-1:0]                saddr_r;
  logic [bfa_pkg::POS_W-1:0]      bpos_r;
  logic [CH_W-1:0]                chunk_r;
  logic                           full_r;
  logic [15:0]                    grant_r;
  logic                           ok_r;
  logic [MW_W-1:0]                clr_r;
  logic [TOP_BITS-1:0]            top_r;
  logic [CW-1:0]                  avail_r;
  logic [CW-1:0]                  used_r;

  logic                           out_valid_r;
  logic [15:0]                    out_grant_r;
  logic                           out_ok_r;
  logic [CW-1:0]                  out_free_r;

  // memories
  logic [W-1:0] map_mem [MAP_WORDS];
  logic [W-1:0] sum_mem [SUM_WORDS];
  logic [W-1:0] map_rd_r;
  logic [W-1:0] sum_rd_r;

  logic            map_we, sum_we;
  logic [MW_W-1:0] map_wa;
  logic [SW_W-1:0] sum_wa;
  logic [W-1:0]    map_wd, sum_wd;

  // input fields
  logic [1:0]  in_action;
  logic [15:0] in_frame;
  logic        in_accept;
  logic        in_range;
  assign in_action = in_tdata[1:0];
  assign in_frame  = in_tdata[17:2];
  assign in_accept = in_tvalid && in_tready;
  assign in_range  = {16'd0, in_frame} < FRAMES_U;

  // shared finder
  logic [W-1:0]      ffz_word;
  bfa_pkg::ffz_res_t ffz;

  bfa_ffz u_ffz (
    .word (ffz_word),
    .res  (ffz)
  );

  // map and summary word update
  logic [bfa_pkg::POS_W-1:0] bsel;
  logic [W-1:0]              bmask;
  logic                      old_bit;
  logic [W-1:0]              map_new;
  logic [bfa_pkg::POS_W-1:0] sbit;
  logic [W-1:0]              smask;
  logic [W-1:0]              sum_new;
  logic                      out_slot;

  assign bsel    = (act_r == bfa_pkg::ACT_ALLOC) ? ffz.pos : bpos_r;
  assign bmask   = W'(1) << bsel;
  assign old_bit = map_rd_r[bsel];
  assign map_new = (act_r == bfa_pkg::ACT_RELEASE || act_r == bfa_pkg::ACT_FREE)
                   ? (map_rd_r & ~bmask) : (map_rd_r | bmask);
  assign sbit    = bfa_pkg::POS_W'(waddr_r);
  assign smask   = W'(1) << sbit;
  assign sum_new = full_r ? (sum_rd_r | smask) : (sum_rd_r & ~smask);
  assign out_slot = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfa_pkg::ST_CLEAR: begin
        if (clr_r == MW_LAST) state_nxt = bfa_pkg::ST_IDLE;
      end
      bfa_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_action == bfa_pkg::ACT_ALLOC) state_nxt = bfa_pkg::ST_TOP_SCAN;
          else if (in_range)                   state_nxt = bfa_pkg::ST_MAP_RD;
          else                                 state_nxt = bfa_pkg::ST_DONE;
        end
      end
      bfa_pkg::ST_TOP_SCAN: begin
        if (ffz.found)               state_nxt = bfa_pkg::ST_SUM_FRD;
        else if (chunk_r == CH_LAST) state_nxt = bfa_pkg::ST_DONE;
      end
      bfa_pkg::ST_SUM_FRD:  state_nxt = bfa_pkg::ST_SUM_FIND;
      bfa_pkg::ST_SUM_FIND: state_nxt = bfa_pkg::ST_MAP_RD;
      bfa_pkg::ST_MAP_RD:   state_nxt = bfa_pkg::ST_MAP_MOD;
      bfa_pkg::ST_MAP_MOD: begin
        if (act_r == bfa_pkg::ACT_FREE && !old_bit) state_nxt = bfa_pkg::ST_DONE;
        else                                         state_nxt = bfa_pkg::ST_SUM_RD;
      end
      bfa_pkg::ST_SUM_RD:  state_nxt = bfa_pkg::ST_SUM_MOD;
      bfa_pkg::ST_SUM_MOD: state_nxt = bfa_pkg::ST_DONE;
      bfa_pkg::ST_DONE: begin
        if (out_slot) state_nxt = bfa_pkg::ST_IDLE;
      end
      default: state_nxt = bfa_pkg::ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    map_we    = 1'b0;
    sum_we    = 1'b0;
    map_wa    = waddr_r;
    sum_wa    = saddr_r;
    map_wd    = map_new;
    sum_wd    = sum_new;
    ffz_word  = map_rd_r;
    case (state_r)
      bfa_pkg::ST_CLEAR: begin
        map_we = 1'b1;
        map_wa = clr_r;
        map_wd = '1;
        sum_we = {{(32-MW_W){1'b0}}, clr_r} < SUM_WORDS_U;
        sum_wa = SW_W'(clr_r);
        sum_wd = '1;
      end
      bfa_pkg::ST_IDLE:     in_tready = 1'b1;
      bfa_pkg::ST_TOP_SCAN: ffz_word  = top_r[TB_W'({chunk_r, 6'd0}) +: W];
      bfa_pkg::ST_SUM_FIND: ffz_word  = sum_rd_r;
      bfa_pkg::ST_MAP_MOD:  map_we    = (act_r != bfa_pkg::ACT_FREE) || old_bit;
      bfa_pkg::ST_SUM_MOD:  sum_we    = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    map_rd_r <= map_mem[waddr_r];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    sum_rd_r <= sum_mem[saddr_r];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfa_pkg::ST_CLEAR;
      clr_r       <= '0;
      top_r       <= '1;
      avail_r     <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == bfa_pkg::ST_CLEAR) clr_r <= clr_r + MW_W'(1);
      if (state_r == bfa_pkg::ST_SUM_MOD) top_r[TB_W'(saddr_r)] <= &sum_new;
      if (state_r == bfa_pkg::ST_MAP_MOD) begin
        case (act_r)
          bfa_pkg::ACT_RELEASE:
            if (avail_r != bfa_pkg::COUNT_MAX) avail_r <= avail_r + CW'(1);
          bfa_pkg::ACT_ALLOC:
            if (used_r != bfa_pkg::COUNT_MAX) used_r <= used_r + CW'(1);
          bfa_pkg::ACT_FREE:
            if (old_bit && used_r != '0) used_r <= used_r - CW'(1);
          default: ;
        endcase
      end
      if (state_r == bfa_pkg::ST_DONE && out_slot) out_valid_r <= 1'b1;
      else if (out_tready)                         out_valid_r <= 1'b0;
    end
  end

  // work and result payload
  always_ff @(posedge clk) begin
    case (state_r)
      bfa_pkg::ST_IDLE: begin
        if (in_accept) begin
          act_r   <= bfa_pkg::action_t'(in_action);
          grant_r <= in_frame;
          ok_r    <= 1'b0;
          chunk_r <= '0;
          waddr_r <= MW_W'(in_frame >> 6);
          saddr_r <= SW_W'(in_frame >> 12);
          bpos_r  <= in_frame[5:0];
        end
      end
      bfa_pkg::ST_TOP_SCAN: begin
        if (ffz.found) saddr_r <= SW_W'({chunk_r, ffz.pos});
        else           chunk_r <= chunk_r + CH_W'(1);
      end
      bfa_pkg::ST_SUM_FIND: waddr_r <= MW_W'({saddr_r, ffz.pos});
      bfa_pkg::ST_MAP_MOD: begin
        full_r <= &map_new;
        if (act_r == bfa_pkg::ACT_ALLOC) begin
          grant_r <= 16'({waddr_r, ffz.pos});
          ok_r    <= 1'b1;
        end else if (act_r == bfa_pkg::ACT_FREE && old_bit) begin
          ok_r <= 1'b1;
        end
      end
      bfa_pkg::ST_DONE: begin
        if (out_slot) begin
          out_grant_r <= grant_r;
          out_ok_r    <= ok_r;
          out_free_r  <= (avail_r > used_r) ? (avail_r - used_r) : '0;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_free_r, out_ok_r, out_grant_r};

  // a clear top bit means its summary word holds a clear bit, and so on down
  a_top_leads_to_summary: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bfa_pkg::ST_SUM_FIND |-> ffz.found)
    else $error("summary word chosen by top level has no clear bit");

  a_summary_leads_to_map: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bfa_pkg::ST_MAP_MOD && act_r == bfa_pkg::ACT_ALLOC) |-> ffz.found)
    else $error("map word chosen by summary has no clear bit");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready)
    else $error("second request taken while one is in work");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bfa_pkg::ST_DONE && out_slot) |=> (out_tvalid && state_r == bfa_pkg::ST_IDLE))
    else $error("finished request did not reach the output register");

endmodule
